/* rtl/sliding_window_min_max_defines.svh */
// Assertion macros for the sliding window min/max block.
// Used by the port checker; no other dependencies.
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

// Concurrent check on the rising clock, off while reset is asserted.
`define SWMM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: check failed");

// Concurrent check that also holds while reset is asserted.
`define SWMM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("%m: check failed");

`endif

/* rtl/swmm_pkg.sv */
// Shared types and constants for the sliding window min/max block.
// No dependencies.
package swmm_pkg;

	// Window depth in samples
	localparam int WINDOW = 64;
	localparam int CNT_W  = $clog2(WINDOW);

	localparam int SAMPLE_W   = 16;
	localparam int XLOW_W     = 7;
	localparam int XHIGH_W    = 6;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 48;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Span ends, truncated to the result widths
	localparam logic [XLOW_W-1:0]  X_LOW_BACK  = XLOW_W'(-(WINDOW - 1));
	localparam logic [XHIGH_W-1:0] X_HIGH_FWD  = XHIGH_W'(WINDOW - 1);

endpackage

/* rtl/swmm_cell.sv */
// One sample cell of the window chain: holds a sample and hands it on.
// Depends on swmm_pkg.
module swmm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  swmm_pkg::sample_t din,
	output swmm_pkg::sample_t dout
);
	import swmm_pkg::*;

	sample_t val_q;

	// Take the neighbor's sample when the chain advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift_en) begin
			val_q <= din;
		end
	end

	assign dout = val_q;

endmodule

/* rtl/sliding_window_min_max.sv */
// One word at a time: the input is taken only in idle, and the result comes after
// one full rotation of the cell chain past the min/max accumulator at the chain's
// tail. The input stays closed while a finished result waits for a busy sink.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low, asynchronous): all cells zero, backwards_mode zero, idle.
// Depends on swmm_pkg and swmm_cell.
module sliding_window_min_max (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic                                cfg_wdata,       // backwards_mode
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [swmm_pkg::IN_DATA_W-1:0]      s_axis_tdata,    // sample_value
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// window_min[15:0], window_max[31:16], x_low[38:32], x_high[44:39], zero pad
	output logic [swmm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import swmm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_HOLD
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	sample_t               lo_q;
	sample_t               hi_q;
	logic                  back_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	sample_t tap_w  [WINDOW];
	sample_t feed_w;
	logic    shift_w;
	logic    accept_w;
	logic    slot_free_w;
	logic    load_out_w;
	sample_t tail_w;
	sample_t lo_nxt_w;
	sample_t hi_nxt_w;

	assign accept_w    = s_axis_tvalid && s_axis_tready;
	assign slot_free_w = !out_valid_q || m_axis_tready;
	assign tail_w      = tap_w[WINDOW-1];

	// Load the output register at the end of a sweep or out of hold
	assign load_out_w = slot_free_w &&
		(((state_q == ST_SWEEP) && (cnt_q == '0)) || (state_q == ST_HOLD));

	// Advance the chain on a new word (oldest drops) or rotate it while sweeping
	assign shift_w = accept_w || (state_q == ST_SWEEP);
	assign feed_w  = (state_q == ST_SWEEP) ? tail_w : sample_t'(s_axis_tdata);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			swmm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_w),
				.din      (feed_w),
				.dout     (tap_w[i])
			);
		end else begin : g_body
			swmm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_w),
				.din      (tap_w[i-1]),
				.dout     (tap_w[i])
			);
		end
	end

	// Fold the tail sample into the running extremes
	assign lo_nxt_w = (tail_w < lo_q) ? tail_w : lo_q;
	assign hi_nxt_w = (tail_w > hi_q) ? tail_w : hi_q;

	function automatic logic [OUT_DATA_W-1:0] pack_result(
		input sample_t lo,
		input sample_t hi,
		input logic    back
	);
		logic [XLOW_W-1:0]  xl;
		logic [XHIGH_W-1:0] xh;
		xl = back ? X_LOW_BACK : '0;
		xh = back ? '0 : X_HIGH_FWD;
		return {{(OUT_DATA_W - 2*SAMPLE_W - XLOW_W - XHIGH_W){1'b0}}, xh, xl, hi, lo};
	endfunction

	// Sequence one word: load, sweep the full chain, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			back_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_wen) begin
				back_q <= cfg_wdata;
			end
			// Raise valid on a new result word, drop it once the sink takes it
			if (load_out_w) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						lo_q    <= sample_t'(s_axis_tdata);
						hi_q    <= sample_t'(s_axis_tdata);
						cnt_q   <= CNT_W'(WINDOW - 1);
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					lo_q  <= lo_nxt_w;
					hi_q  <= hi_nxt_w;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						if (slot_free_w) begin
							out_data_q <= pack_result(lo_nxt_w, hi_nxt_w, back_q);
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (slot_free_w) begin
						out_data_q <= pack_result(lo_q, hi_q, back_q);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/swmm_checker.sv */
// Port-level checks for sliding_window_min_max, bound to the top level.
// Depends on swmm_pkg and sliding_window_min_max_defines.svh.
`include "sliding_window_min_max_defines.svh"

module swmm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [swmm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import swmm_pkg::*;

	// A taken word keeps the input closed while the chain sweeps
	`SWMM_ASSERT(a_busy_after_accept, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

	// Span ends always form one of the two legal pairs
	`SWMM_ASSERT(a_span_pair, clk, arst_n, m_axis_tvalid |-> ((m_axis_tdata[38:32] == '0 && m_axis_tdata[44:39] == X_HIGH_FWD) || (m_axis_tdata[38:32] == X_LOW_BACK && m_axis_tdata[44:39] == '0)))

	// Minimum never exceeds maximum
	`SWMM_ASSERT(a_min_le_max, clk, arst_n, m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[31:16])))

	// Stalled result word holds
	`SWMM_ASSERT(a_out_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
